// File: hw/rtl/lfs_pkg.sv
// Shared constants, arctangent table and pipeline payload type for the steering block.
package lfs_pkg;

  // Default CORDIC iteration count and the length of the arctangent table.
  localparam int CordicStepsDef = 16;
  localparam int TableLen       = 24;

  // Internal widths: x/y carry the 2^8 prescale plus CORDIC growth, z is Q.20.
  localparam int XW = 28;
  localparam int ZW = 25;
  localparam int PosW  = 16;

  localparam int Prescale = 8;
  localparam int AngFrac  = 20;

  localparam logic signed [ZW-1:0] PiQ20   = ZW'(3294199);
  localparam logic        [19:0]   InvKQ20 = 20'd636751;

  localparam logic [16:0] DistMax = 17'd131071;
  localparam logic signed [19:0] AngMax = 20'sd65535;
  localparam logic signed [19:0] AngMin = -20'sd65536;

  // Configuration register defaults and indexes.
  localparam logic [15:0] GainRst = 16'd19661;
  localparam logic [15:0] TolRst  = 16'd3072;
  localparam logic        RegGain = 1'b0;
  localparam logic        RegTol  = 1'b1;

  // atan(2^-i) rounded to Q.20
  localparam logic signed [ZW-1:0] AtanQ20 [TableLen] = '{
    ZW'(823550), ZW'(486170), ZW'(256879), ZW'(130396),
    ZW'(65451),  ZW'(32757),  ZW'(16383),  ZW'(8192),
    ZW'(4096),   ZW'(2048),   ZW'(1024),   ZW'(512),
    ZW'(256),    ZW'(128),    ZW'(64),     ZW'(32),
    ZW'(16),     ZW'(8),      ZW'(4),      ZW'(2),
    ZW'(1),      ZW'(0),      ZW'(0),      ZW'(0)
  };

  // Payload carried through the CORDIC stages.
  typedef struct packed {
    logic                   zero;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
    logic signed [PosW-1:0] hd;
  } cordic_t;

endpackage

// File: hw/rtl/lfs_cordic_stage.sv
// One registered CORDIC vectoring iteration.
module lfs_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  lfs_pkg::cordic_t data_i,
  output logic             valid_o,
  output lfs_pkg::cordic_t data_o
);

  logic             valid_q;
  lfs_pkg::cordic_t data_d, data_q;
  logic signed [lfs_pkg::XW-1:0] xs, ys;

  always_comb begin
    xs     = data_i.x >>> STEP;
    ys     = data_i.y >>> STEP;
    data_d = data_i;
    if (!data_i.y[lfs_pkg::XW-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + lfs_pkg::AtanQ20[STEP];
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - lfs_pkg::AtanQ20[STEP];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/leader_follower_steering.sv
// Top level of the leader/follower go-to-goal steering pipeline.
//
// Pose samples go in on start (accepted whenever busy is low, and busy is
// never raised), one transaction per clock. Each sample forms dx/dy from the
// leader and follower positions, runs CORDIC_STEPS unrolled vectoring
// iterations for distance and bearing, and, when the distance reaches the
// trigger tolerance (tol), gives one command on linear_velocity_o and
// angular_velocity_o flagged by valid_o for a single cycle. Samples whose
// distance falls short give no transaction. The receiver cannot stall the
// block: there are CORDIC_STEPS + 6 register stages, so commands reach the
// ports in acceptance order, and the throughput is one sample per clock,
// set by the fully pipelined CORDIC (one register stage per iteration).
// Stages: input difference, quadrant fold, CORDIC_STEPS iterations,
// 1/K scaling multiply, rounding and threshold, gain multiplies, output
// rounding and saturation. No angle wrap is applied to bearing minus
// heading. gain (Q0.16) and the trigger tolerance tol (Q5.11) sit on an APB
// port at byte addresses 0 and 4; write them only while the pipeline is empty.
module leader_follower_steering #(
  parameter int CORDIC_STEPS = lfs_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command interface
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] leader_x_i,
  input  logic signed [15:0] leader_y_i,
  input  logic signed [15:0] follower_x_i,
  input  logic signed [15:0] follower_y_i,
  input  logic signed [15:0] follower_heading_i,
  output logic               valid_o,
  output logic        [16:0] linear_velocity_o,
  output logic signed [16:0] angular_velocity_o,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam int XW = lfs_pkg::XW;
  localparam int ZW = lfs_pkg::ZW;
  localparam int ProdW = XW + 21;          // x times unsigned 1/K
  localparam int Shift = lfs_pkg::AngFrac + lfs_pkg::Prescale;
  localparam int DW    = ProdW - Shift;    // distance before clamp
  localparam int BrgW  = ZW - (lfs_pkg::AngFrac - 13);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] gain_q, tol_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= lfs_pkg::GainRst;
      tol_q  <= lfs_pkg::TolRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lfs_pkg::RegGain: gain_q <= pwdata[15:0];
        lfs_pkg::RegTol:  tol_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lfs_pkg::RegGain: prdata = {16'd0, gain_q};
      lfs_pkg::RegTol:  prdata = {16'd0, tol_q};
      default:          prdata = 32'd0;
    endcase
  end

  // No back-pressure anywhere: every stage advances each cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 0: position differences (exact, 17 bit Q6.11)
  // ---------------------------------------------------------------------
  logic                     v0_q;
  logic signed [16:0]       dx_q, dy_q;
  logic signed [15:0]       hd0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= {leader_x_i[15], leader_x_i} - {follower_x_i[15], follower_x_i};
    dy_q  <= {leader_y_i[15], leader_y_i} - {follower_y_i[15], follower_y_i};
    hd0_q <= follower_heading_i;
  end

  // ---------------------------------------------------------------------
  // Stage 1: fold left half-plane onto the right, start angle at +-pi
  // ---------------------------------------------------------------------
  logic             v1_q;
  lfs_pkg::cordic_t c1_d, c1_q;
  logic signed [XW-1:0] dx_w, dy_w;

  always_comb begin
    dx_w = {{(XW-17){dx_q[16]}}, dx_q} <<< lfs_pkg::Prescale;
    dy_w = {{(XW-17){dy_q[16]}}, dy_q} <<< lfs_pkg::Prescale;
    c1_d.zero = (dx_q == 17'sd0) && (dy_q == 17'sd0);
    c1_d.hd   = hd0_q;
    if (dx_q[16]) begin
      c1_d.x = -dx_w;
      c1_d.y = -dy_w;
      c1_d.z = dy_q[16] ? -lfs_pkg::PiQ20 : lfs_pkg::PiQ20;
    end else begin
      c1_d.x = dx_w;
      c1_d.y = dy_w;
      c1_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= c1_d;
  end

  // ---------------------------------------------------------------------
  // CORDIC iterations, one register stage each
  // ---------------------------------------------------------------------
  logic             cv [CORDIC_STEPS+1];
  lfs_pkg::cordic_t cd [CORDIC_STEPS+1];

  assign cv[0] = v1_q;
  assign cd[0] = c1_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    lfs_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .data_i  (cd[i]),
      .valid_o (cv[i+1]),
      .data_o  (cd[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Stage P: x times 1/K, bearing rounded to Q3.13
  // ---------------------------------------------------------------------
  lfs_pkg::cordic_t   cf;
  logic               vp_q, zp_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [BrgW-1:0]  brg_q;
  logic signed [15:0]      hdp_q;
  logic signed [ZW-1:0]    zr;

  assign cf = cd[CORDIC_STEPS];
  assign zr = cf.z + ZW'(64);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(cf.x) * $signed({1'b0, lfs_pkg::InvKQ20});
    brg_q  <= zr[ZW-1:lfs_pkg::AngFrac-13];
    zp_q   <= cf.zero;
    hdp_q  <= cf.hd;
  end

  // ---------------------------------------------------------------------
  // Stage D: distance rounding and clamp, tolerance test, angle error
  // ---------------------------------------------------------------------
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [DW-1:0]    dist_raw;
  logic        [16:0]      dist_d, dist_q;
  logic signed [18:0]      diff_d, diff_q;
  logic                    trig_d, vd_q;

  assign prod_rnd = prod_q + (ProdW'(1) <<< (Shift - 1));
  assign dist_raw = prod_rnd[ProdW-1:Shift];

  always_comb begin
    priority if (zp_q || dist_raw[DW-1]) begin
      dist_d = '0;
    end else if (dist_raw > $signed({{(DW-17){1'b0}}, lfs_pkg::DistMax})) begin
      dist_d = lfs_pkg::DistMax;
    end else begin
      dist_d = dist_raw[16:0];
    end
    diff_d = zp_q ? -{{3{hdp_q[15]}}, hdp_q}
                  : {{(19-BrgW){brg_q[BrgW-1]}}, brg_q} - {{3{hdp_q[15]}}, hdp_q};
    trig_d = dist_d >= {1'b0, tol_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vp_q && trig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    diff_q <= diff_d;
  end

  // ---------------------------------------------------------------------
  // Stage G: gain products
  // ---------------------------------------------------------------------
  logic                vg_q;
  logic        [32:0]  lin_prod_q;
  logic signed [35:0]  ang_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else begin
      vg_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lin_prod_q <= gain_q * dist_q;
    ang_prod_q <= $signed({20'd0, gain_q}) * 36'(diff_q);
  end

  // ---------------------------------------------------------------------
  // Stage O: round, saturate, present for one cycle
  // ---------------------------------------------------------------------
  logic        [33:0] lin_sum;
  logic signed [35:0] ang_sum;
  logic signed [19:0] ang_raw;
  logic        [16:0] lin_d, lin_q;
  logic signed [16:0] ang_d, ang_q;
  logic               vo_q;

  assign lin_sum = {1'b0, lin_prod_q} + 34'd32768;
  assign ang_sum = ang_prod_q + 36'sd32768;
  assign ang_raw = ang_sum[35:16];

  // gain < 1, so the linear product never exceeds the 17 bit range
  assign lin_d = lin_sum[32:16];

  always_comb begin
    priority if (ang_raw > lfs_pkg::AngMax) begin
      ang_d = 17'(lfs_pkg::AngMax);
    end else if (ang_raw < lfs_pkg::AngMin) begin
      ang_d = 17'(lfs_pkg::AngMin);
    end else begin
      ang_d = ang_raw[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lin_q <= lin_d;
    ang_q <= ang_d;
  end

  assign valid_o            = vo_q;
  assign linear_velocity_o  = lin_q;
  assign angular_velocity_o = ang_q;

endmodule
